@@ src/segment_intersection_test_core_assert.svh @@
// Assertion macros for the segment intersection checker.
`ifndef SEGMENT_INTERSECTION_TEST_CORE_ASSERT_SVH
`define SEGMENT_INTERSECTION_TEST_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define SIT_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define SIT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/seg_isect_pkg.sv @@
// Shared constants for the segment intersection test core.
`default_nettype none

package seg_isect_pkg;

  // Default coordinate width of each input field.
  localparam int unsigned CoordBitsDef = 24;
  // Default fraction bits of the t result (Q2.FRAC).
  localparam int unsigned FracBitsDef  = 16;

endpackage

`default_nettype wire

@@ src/segment_intersection_test_core.sv @@
// Pipelined closed 2-D segment intersection test with fixed-point parameter output.
`default_nettype none

// Takes one pair of segments (start point plus direction each) per cycle and returns
// one result per pair, in order. The stages are delta, cross-product multiply, subtract,
// magnitude, bounds classification, FRAC_BITS + 1 restoring-divider stages that each
// settle one quotient bit of t, and a rounding/output register. Sustained rate is one
// pair per clock; every stage holds under back-pressure and empty stages fill while the
// output waits.

module segment_intersection_test_core #(
  parameter int unsigned COORD_BITS = seg_isect_pkg::CoordBitsDef,
  parameter int unsigned FRAC_BITS  = seg_isect_pkg::FracBitsDef
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output      logic                              in_ready_o,
  input  wire logic signed [COORD_BITS-1:0]      a_x_i,
  input  wire logic signed [COORD_BITS-1:0]      a_y_i,
  input  wire logic signed [COORD_BITS-1:0]      a_dx_i,
  input  wire logic signed [COORD_BITS-1:0]      a_dy_i,
  input  wire logic signed [COORD_BITS-1:0]      b_x_i,
  input  wire logic signed [COORD_BITS-1:0]      b_y_i,
  input  wire logic signed [COORD_BITS-1:0]      b_dx_i,
  input  wire logic signed [COORD_BITS-1:0]      b_dy_i,
  output      logic                              out_valid_o,
  input  wire logic                              out_ready_i,
  output      logic                              hit_o,
  output      logic                              hit_distinct_o,
  output      logic signed [2*COORD_BITS+1:0]    ratio_num_o,
  output      logic signed [2*COORD_BITS+1:0]    ratio_den_o,
  output      logic signed [FRAC_BITS+1:0]       t_fixed_o
);

  localparam int unsigned DW    = COORD_BITS + 1;     // start delta
  localparam int unsigned PW    = 2 * COORD_BITS;     // direction x direction product
  localparam int unsigned QPW   = 2 * COORD_BITS + 1; // delta x direction product
  localparam int unsigned DenW  = 2 * COORD_BITS + 1;
  localparam int unsigned NumW  = 2 * COORD_BITS + 2;
  localparam int unsigned MagW  = NumW;
  localparam int unsigned QW    = FRAC_BITS + 1;
  localparam int unsigned TW    = FRAC_BITS + 2;
  localparam int unsigned DivN  = FRAC_BITS + 1;

  localparam int unsigned StDelta = 0;
  localparam int unsigned StProd  = 1;
  localparam int unsigned StCross = 2;
  localparam int unsigned StMag   = 3;
  localparam int unsigned StClass = 4;
  localparam int unsigned StDiv   = 5;
  localparam int unsigned StOut   = StDiv + DivN;
  localparam int unsigned NStg    = StOut + 1;

  localparam logic signed [TW-1:0] TOne = TW'(1) << FRAC_BITS;

  typedef struct packed {
    logic                   hit;
    logic                   distinct;
    logic signed [NumW-1:0] num;
    logic signed [NumW-1:0] den;
    logic [MagW-1:0]        dmag;
  } side_t;

  // Stage valids and per-stage advance (a stage loads when empty or when the next one loads)
  logic [NStg-1:0] vld_q;
  logic [NStg-1:0] adv;

  assign adv[StOut] = ~vld_q[StOut] | out_ready_i;
  for (genvar k = 0; k < StOut; k++) begin : g_adv
    assign adv[k] = ~vld_q[k] | adv[k+1];
  end

  assign in_ready_o  = adv[StDelta];
  assign out_valid_o = vld_q[StOut];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[StDelta]) vld_q[StDelta] <= in_valid_i;
      for (int k = 1; k < NStg; k++) begin
        if (adv[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // Stage 0: start delta, capture directions
  logic signed [DW-1:0]         s0_dx_q, s0_dy_q;
  logic signed [COORD_BITS-1:0] s0_adx_q, s0_ady_q, s0_bdx_q, s0_bdy_q;

  always_ff @(posedge clk_i) begin
    if (adv[StDelta]) begin
      s0_dx_q  <= DW'(b_x_i) - DW'(a_x_i);
      s0_dy_q  <= DW'(b_y_i) - DW'(a_y_i);
      s0_adx_q <= a_dx_i;
      s0_ady_q <= a_dy_i;
      s0_bdx_q <= b_dx_i;
      s0_bdy_q <= b_dy_i;
    end
  end

  // Stage 1: six products
  logic signed [PW-1:0]  s1_den_a_q, s1_den_b_q;
  logic signed [QPW-1:0] s1_num_a_q, s1_num_b_q, s1_ub_a_q, s1_ub_b_q;

  always_ff @(posedge clk_i) begin
    if (adv[StProd]) begin
      s1_den_a_q <= PW'(s0_adx_q) * PW'(s0_bdy_q);
      s1_den_b_q <= PW'(s0_ady_q) * PW'(s0_bdx_q);
      s1_num_a_q <= QPW'(s0_dx_q) * QPW'(s0_bdy_q);
      s1_num_b_q <= QPW'(s0_dy_q) * QPW'(s0_bdx_q);
      s1_ub_a_q  <= QPW'(s0_dx_q) * QPW'(s0_ady_q);
      s1_ub_b_q  <= QPW'(s0_dy_q) * QPW'(s0_adx_q);
    end
  end

  // Stage 2: cross products
  logic signed [DenW-1:0] s2_den_q;
  logic signed [NumW-1:0] s2_num_q, s2_ub_q;

  always_ff @(posedge clk_i) begin
    if (adv[StCross]) begin
      s2_den_q <= DenW'(s1_den_a_q) - DenW'(s1_den_b_q);
      s2_num_q <= NumW'(s1_num_a_q) - NumW'(s1_num_b_q);
      s2_ub_q  <= NumW'(s1_ub_a_q) - NumW'(s1_ub_b_q);
    end
  end

  // Stage 3: magnitudes and signs
  logic signed [DenW-1:0] s2_den_abs;
  logic signed [NumW-1:0] s2_num_abs, s2_ub_abs;

  assign s2_den_abs = s2_den_q[DenW-1] ? -s2_den_q : s2_den_q;
  assign s2_num_abs = s2_num_q[NumW-1] ? -s2_num_q : s2_num_q;
  assign s2_ub_abs  = s2_ub_q[NumW-1]  ? -s2_ub_q  : s2_ub_q;

  logic signed [DenW-1:0] s3_den_q;
  logic signed [NumW-1:0] s3_num_q;
  logic [MagW-1:0]        s3_dmag_q, s3_nmag_q, s3_umag_q;
  logic                   s3_den_neg_q, s3_num_neg_q, s3_ub_neg_q;
  logic                   s3_den_nz_q, s3_num_nz_q, s3_ub_nz_q;

  always_ff @(posedge clk_i) begin
    if (adv[StMag]) begin
      s3_den_q     <= s2_den_q;
      s3_num_q     <= s2_num_q;
      s3_dmag_q    <= MagW'($unsigned(s2_den_abs));
      s3_nmag_q    <= $unsigned(s2_num_abs);
      s3_umag_q    <= $unsigned(s2_ub_abs);
      s3_den_neg_q <= s2_den_q[DenW-1];
      s3_num_neg_q <= s2_num_q[NumW-1];
      s3_ub_neg_q  <= s2_ub_q[NumW-1];
      s3_den_nz_q  <= (s2_den_q != '0);
      s3_num_nz_q  <= (s2_num_q != '0);
      s3_ub_nz_q   <= (s2_ub_q != '0);
    end
  end

  // Stage 4: bounds test on both parameters
  logic  num_in, ub_in, s3_hit;
  side_t s3_side;

  // a zero numerator is inside whatever the sign of the denominator
  assign num_in = (~s3_num_nz_q | (s3_num_neg_q == s3_den_neg_q)) & (s3_nmag_q <= s3_dmag_q);
  assign ub_in  = (~s3_ub_nz_q  | (s3_ub_neg_q  == s3_den_neg_q)) & (s3_umag_q <= s3_dmag_q);
  assign s3_hit = s3_den_nz_q & num_in & ub_in;

  always_comb begin
    s3_side.hit      = s3_hit;
    s3_side.distinct = s3_hit & s3_num_nz_q & (s3_nmag_q < s3_dmag_q);
    s3_side.num      = s3_den_nz_q ? s3_num_q : '0;
    s3_side.den      = s3_hit ? NumW'(s3_den_q) : '0;
    s3_side.dmag     = s3_dmag_q;
  end

  side_t           s4_side_q;
  logic [MagW-1:0] s4_nmag_q;

  always_ff @(posedge clk_i) begin
    if (adv[StClass]) begin
      s4_side_q <= s3_side;
      s4_nmag_q <= s3_nmag_q;
    end
  end

  // Restoring divider: one quotient bit per stage, integer bit first
  logic [MagW-1:0] rem_q  [DivN];
  logic [QW-1:0]   quo_q  [DivN];
  side_t           side_q [DivN];

  for (genvar i = 0; i < DivN; i++) begin : g_div
    logic [MagW-1:0] rem_in;
    logic [QW-1:0]   quo_in;
    side_t           side_in;
    logic            ge;

    if (i == 0) begin : g_first
      assign rem_in  = s4_nmag_q;
      assign quo_in  = '0;
      assign side_in = s4_side_q;
    end else begin : g_next
      assign rem_in  = {rem_q[i-1][MagW-2:0], 1'b0};
      assign quo_in  = quo_q[i-1];
      assign side_in = side_q[i-1];
    end

    assign ge = (rem_in >= side_in.dmag);

    always_ff @(posedge clk_i) begin
      if (adv[StDiv+i]) begin
        rem_q[i]  <= ge ? (rem_in - side_in.dmag) : rem_in;
        quo_q[i]  <= {quo_in[QW-2:0], ge};
        side_q[i] <= side_in;
      end
    end
  end

  // Output stage: round half up, substitute -1.0 on a miss
  logic              rnd_up;
  logic [TW-1:0]     t_rnd;
  side_t             last_side;

  assign last_side = side_q[DivN-1];
  assign rnd_up    = ({rem_q[DivN-1][MagW-2:0], 1'b0} >= last_side.dmag);
  assign t_rnd     = TW'(quo_q[DivN-1]) + TW'(rnd_up);

  logic                   out_hit_q, out_distinct_q;
  logic signed [NumW-1:0] out_num_q, out_den_q;
  logic signed [TW-1:0]   out_t_q;

  always_ff @(posedge clk_i) begin
    if (adv[StOut]) begin
      out_hit_q      <= last_side.hit;
      out_distinct_q <= last_side.distinct;
      out_num_q      <= last_side.num;
      out_den_q      <= last_side.den;
      out_t_q        <= last_side.hit ? $signed(t_rnd) : -TOne;
    end
  end

  assign hit_o          = out_hit_q;
  assign hit_distinct_o = out_distinct_q;
  assign ratio_num_o    = out_num_q;
  assign ratio_den_o    = out_den_q;
  assign t_fixed_o      = out_t_q;

endmodule

`default_nettype wire

@@ src/seg_isect_chk.sv @@
// Port-level checker for the segment intersection test core, bound to the top level.
`default_nettype none

`include "segment_intersection_test_core_assert.svh"

module seg_isect_chk #(
  parameter int unsigned COORD_BITS = seg_isect_pkg::CoordBitsDef,
  parameter int unsigned FRAC_BITS  = seg_isect_pkg::FracBitsDef
) (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           out_valid_o,
  input wire logic                           out_ready_i,
  input wire logic                           hit_o,
  input wire logic                           hit_distinct_o,
  input wire logic signed [2*COORD_BITS+1:0] ratio_num_o,
  input wire logic signed [2*COORD_BITS+1:0] ratio_den_o,
  input wire logic signed [FRAC_BITS+1:0]    t_fixed_o
);

  localparam int unsigned TW   = FRAC_BITS + 2;
  localparam int unsigned OutW = 2 + 2 * (2 * COORD_BITS + 2) + TW;
  localparam logic signed [TW-1:0] TOne = TW'(1) << FRAC_BITS;

  logic            out_stall, out_miss, out_hit;
  logic [OutW-1:0] out_bits;

  assign out_stall = out_valid_o && !out_ready_i;
  assign out_miss  = out_valid_o && !hit_o;
  assign out_hit   = out_valid_o && hit_o;
  assign out_bits  = {hit_o, hit_distinct_o, ratio_num_o, ratio_den_o, t_fixed_o};

  `SIT_ASSERT(a_miss_t, out_miss, t_fixed_o == -TOne, "miss must give t of -1.0")

  `SIT_ASSERT(a_miss_den, out_miss, ratio_den_o == '0, "miss must zero the denominator")

  `SIT_ASSERT(a_distinct_hit, out_valid_o && hit_distinct_o, hit_o, "distinct hit without hit")

  `SIT_ASSERT(a_hit_t_range, out_hit, t_fixed_o >= 0 && t_fixed_o <= TOne, "hit t out of range")

  `SIT_ASSERT_NXT(a_out_hold, out_stall, out_valid_o && $stable(out_bits), "held result changed")

endmodule

bind segment_intersection_test_core seg_isect_chk #(
  .COORD_BITS(COORD_BITS),
  .FRAC_BITS (FRAC_BITS)
) u_seg_isect_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .hit_o         (hit_o),
  .hit_distinct_o(hit_distinct_o),
  .ratio_num_o   (ratio_num_o),
  .ratio_den_o   (ratio_den_o),
  .t_fixed_o     (t_fixed_o)
);

`default_nettype wire
